// ===== rtl/heart_rate_peak_detector_core_defines.svh =====
// Assertion macros shared by the heart rate peak detector RTL.
`ifndef HEART_RATE_PEAK_DETECTOR_CORE_DEFINES_SVH
`define HEART_RATE_PEAK_DETECTOR_CORE_DEFINES_SVH

// Checks that a condition holds on every clock edge outside reset.
`define HRPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a trigger in one cycle implies a consequence in the next cycle.
`define HRPD_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrpd_pkg.sv =====
// Shared widths, reset values and register indexes of the heart rate peak detector.
`timescale 1ns / 1ps
`default_nettype none

package hrpd_pkg;

    // Field and state widths.
    localparam int SAMPLE_W      = 12;
    localparam int THR_W         = 12;
    localparam int INTV_W        = 16;
    localparam int LEVEL_W       = 20;
    localparam int RATE_W        = 17;
    localparam int TALLY_W       = 16;
    localparam int TIME_WIDTH    = 32;
    localparam int FRACTION_BITS = 8;

    // Shared serial divider: dividend, divisor and step counter widths.
    localparam int DIV_W     = 24;
    localparam int DIVR_W    = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int SUM_W     = 21;

    // Reciprocal multiplier for the divisions by five and ten.
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 25;
    localparam int MUL_W       = DIV_W + RECIP_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD  = 3'd4;

    // Register reset values.
    localparam logic [THR_W-1:0]  RST_LOW_THRESHOLD  = 12'd1000;
    localparam logic [THR_W-1:0]  RST_HIGH_THRESHOLD = 12'd2400;
    localparam logic [INTV_W-1:0] RST_MIN_INTERVAL   = 16'd200;
    localparam logic [INTV_W-1:0] RST_MAX_INTERVAL   = 16'd2000;
    localparam logic [INTV_W-1:0] RST_REPORT_PERIOD  = 16'd6000;

    // Arithmetic constants.
    localparam logic [DIV_W-1:0]   RATE_NUMER  = DIV_W'(60000 * (2 ** FRACTION_BITS));
    localparam logic [RATE_W-1:0]  RATE_MAX    = {RATE_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_MAX   = {TALLY_W{1'b1}};
    // Rounded-up reciprocal of five scaled by 2^25; exact for dividends below about 11 million.
    localparam logic [RECIP_W-1:0] RECIP_FIVE  = RECIP_W'(((2 ** RECIP_SHIFT) + 4) / 5);

endpackage

`default_nettype wire

// ===== rtl/heart_rate_peak_detector_core.sv =====
// Heart rate peak detector: filter, peak detection, rate and smoothing on one serial divider.
// A new sample is accepted only while the sequencer is idle; the 24-step restoring divider
// computes the rate on an accepted beat, and one reciprocal multiplier divides the filter
// and average by constants.
// The next sample is taken while the previous result still waits on the output register.
// Reset (synchronous, active low) restores the register defaults and clears all beat state.
`timescale 1ns / 1ps
`default_nettype none

`include "heart_rate_peak_detector_core_defines.svh"

module heart_rate_peak_detector_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [hrpd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [hrpd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Sample stream in.
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: sample [11:0], zero padding [15:12].
    input  wire logic [hrpd_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Result stream out.
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: filtered_level [19:0], peak_seen [20], beat_accepted [21],
    // smoothed_rate [38:22], beat_count [54:39], report_due [55].
    output logic [hrpd_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata
);

    import hrpd_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LVL_DIV  = 3'd1;
    localparam logic [2:0] S_DETECT   = 3'd2;
    localparam logic [2:0] S_RATE_DIV = 3'd3;
    localparam logic [2:0] S_PUSH     = 3'd4;
    localparam logic [2:0] S_SUM      = 3'd5;
    localparam logic [2:0] S_AVG_DIV  = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    // Configuration registers.
    logic [THR_W-1:0]  r_low_thr;
    logic [THR_W-1:0]  r_high_thr;
    logic [INTV_W-1:0] r_min_intv;
    logic [INTV_W-1:0] r_max_intv;
    logic [INTV_W-1:0] r_period;

    // Sequencer and beat state.
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [LEVEL_W-1:0]    r_level;
    logic                  r_armed;
    logic [TIME_WIDTH-1:0] r_tick;
    logic [TIME_WIDTH-1:0] r_last_peak;
    logic [RATE_W-1:0]     r_hist [3];
    logic [1:0]            r_slot;
    logic [RATE_W-1:0]     r_smoothed;
    logic [TALLY_W-1:0]    r_tally;
    logic [INTV_W-1:0]     r_countdown;
    logic                  r_peak;
    logic                  r_acc;
    logic                  r_due;

    // Shared divider registers.
    logic [DIVR_W-1:0]    r_div_rem;
    logic [DIVR_W-1:0]    n_div_rem;
    logic [DIV_W-1:0]     r_div_quo;
    logic [DIV_W-1:0]     n_div_quo;
    logic [DIVR_W-1:0]    r_div_den;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Datapath helpers.
    logic                  in_fire;
    logic                  out_free;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVR_W:0]       div_trial;
    logic [MUL_W-1:0]      recip_prod;
    logic [DIV_W-1:0]      quot_five;
    logic [DIV_W-1:0]      level_dividend;
    logic [LEVEL_W-1:0]    new_level;
    logic [TIME_WIDTH-1:0] interval;
    logic                  peak_now;
    logic                  acc_now;
    logic [INTV_W-1:0]     countdown_inc;
    logic [RATE_W-1:0]     rate_sat;
    logic [RATE_W-1:0]     h_newest;
    logic [RATE_W-1:0]     h_middle;
    logic [RATE_W-1:0]     h_oldest;
    logic [SUM_W-1:0]      avg_sum;
    logic [RATE_W-1:0]     smoothed_out;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign div_busy = (r_state == S_RATE_DIV);
    assign div_done = div_busy && (r_div_cnt == DIV_LAST);

    // One restoring division step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        div_trial = {r_div_rem, r_div_quo[DIV_W-1]};
        if (div_trial >= {1'b0, r_div_den}) begin
            n_div_rem = DIVR_W'(div_trial - {1'b0, r_div_den});
            n_div_quo = {r_div_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_div_rem = div_trial[DIVR_W-1:0];
            n_div_quo = {r_div_quo[DIV_W-2:0], 1'b0};
        end
    end

    // Division by five as a multiply by the scaled reciprocal; halving it gives a tenth.
    assign recip_prod = MUL_W'(r_div_quo) * MUL_W'(RECIP_FIVE);
    assign quot_five  = DIV_W'(recip_prod >> RECIP_SHIFT);

    // Filter numerator 4*level + sample in Q16.8; the level itself is Q12.8.
    assign level_dividend = DIV_W'({r_level, 2'b00}) +
                            DIV_W'({i_s_axis_tdata[SAMPLE_W-1:0], FRACTION_BITS'(0)});

    // Peak test on the freshly divided level; the interval wraps with the tick counter.
    assign new_level = r_div_quo[LEVEL_W-1:0];
    assign interval  = r_tick - r_last_peak;
    assign peak_now  = (new_level > LEVEL_W'({r_high_thr, FRACTION_BITS'(0)})) && !r_armed;
    assign acc_now   = peak_now && (interval > TIME_WIDTH'(r_min_intv)) &&
                       (interval < TIME_WIDTH'(r_max_intv));

    assign countdown_inc = r_countdown + INTV_W'(1);

    // The rate quotient saturates at the field maximum.
    assign rate_sat = (r_div_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : r_div_quo[RATE_W-1:0];

    // Weighted history sum 6*newest + 3*middle + oldest.
    always_comb begin
        case (r_slot)
            2'd0: begin
                h_newest = r_hist[0];
                h_middle = r_hist[2];
                h_oldest = r_hist[1];
            end
            2'd1: begin
                h_newest = r_hist[1];
                h_middle = r_hist[0];
                h_oldest = r_hist[2];
            end
            default: begin
                h_newest = r_hist[2];
                h_middle = r_hist[1];
                h_oldest = r_hist[0];
            end
        endcase
        avg_sum = SUM_W'({h_newest, 2'b00}) + SUM_W'({h_newest, 1'b0}) +
                  SUM_W'({h_middle, 1'b0}) + SUM_W'(h_middle) + SUM_W'(h_oldest);
    end

    assign smoothed_out = r_acc ? r_div_quo[RATE_W-1:0] : r_smoothed;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_LVL_DIV;
            end
            S_LVL_DIV: begin
                n_state = S_DETECT;
            end
            S_DETECT: begin
                n_state = acc_now ? S_RATE_DIV : S_FINISH;
            end
            S_RATE_DIV: begin
                if (div_done) n_state = S_PUSH;
            end
            S_PUSH: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and beat bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low_thr   <= RST_LOW_THRESHOLD;
            r_high_thr  <= RST_HIGH_THRESHOLD;
            r_min_intv  <= RST_MIN_INTERVAL;
            r_max_intv  <= RST_MAX_INTERVAL;
            r_period    <= RST_REPORT_PERIOD;
            r_level     <= '0;
            r_armed     <= 1'b0;
            r_tick      <= '0;
            r_last_peak <= '0;
            r_hist[0]   <= '0;
            r_hist[1]   <= '0;
            r_hist[2]   <= '0;
            r_slot      <= '0;
            r_smoothed  <= '0;
            r_tally     <= '0;
            r_countdown <= '0;
            r_peak      <= 1'b0;
            r_acc       <= 1'b0;
            r_due       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes; indexes beyond the list are ignored.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LOW_THRESHOLD:  r_low_thr  <= i_cfg_wdata[THR_W-1:0];
                    CFG_HIGH_THRESHOLD: r_high_thr <= i_cfg_wdata[THR_W-1:0];
                    CFG_MIN_INTERVAL:   r_min_intv <= i_cfg_wdata[INTV_W-1:0];
                    CFG_MAX_INTERVAL:   r_max_intv <= i_cfg_wdata[INTV_W-1:0];
                    CFG_REPORT_PERIOD:  r_period   <= i_cfg_wdata[INTV_W-1:0];
                    default: begin
                    end
                endcase
            end

            // A new tick advances time and the report countdown.
            if (in_fire) begin
                r_tick <= r_tick + TIME_WIDTH'(1);
                if (countdown_inc >= r_period) begin
                    r_due       <= 1'b1;
                    r_countdown <= '0;
                end else begin
                    r_due       <= 1'b0;
                    r_countdown <= countdown_inc;
                end
            end

            // Level update, peak detection and rearm.
            if (r_state == S_DETECT) begin
                r_level <= new_level;
                r_peak  <= peak_now;
                r_acc   <= acc_now;
                if (peak_now) begin
                    r_last_peak <= r_tick;
                    r_armed     <= 1'b1;
                end else if (new_level < LEVEL_W'({r_low_thr, FRACTION_BITS'(0)})) begin
                    r_armed <= 1'b0;
                end
                if (acc_now && (r_tally != TALLY_MAX)) begin
                    r_tally <= r_tally + TALLY_W'(1);
                end
            end

            // The new rate enters the history at the current slot.
            if (r_state == S_PUSH) begin
                r_hist[r_slot] <= rate_sat;
            end
            if (r_state == S_SUM) begin
                r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
            end

            // Output register handover.
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
                r_smoothed  <= smoothed_out;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared divider, multiplier operand and output payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_fire) begin
            r_div_quo <= level_dividend;
        end else if (r_state == S_LVL_DIV) begin
            r_div_quo <= quot_five;
        end else if ((r_state == S_DETECT) && acc_now) begin
            r_div_rem <= '0;
            r_div_quo <= RATE_NUMER;
            r_div_den <= interval[DIVR_W-1:0];
            r_div_cnt <= '0;
        end else if (r_state == S_SUM) begin
            r_div_quo <= DIV_W'(avg_sum);
        end else if (r_state == S_AVG_DIV) begin
            r_div_quo <= {1'b0, quot_five[DIV_W-1:1]};
        end else if (div_busy) begin
            r_div_rem <= n_div_rem;
            r_div_quo <= n_div_quo;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end

        if ((r_state == S_FINISH) && out_free) begin
            r_out_data <= {r_due, r_tally, smoothed_out, r_acc, r_peak, r_level};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The divider remainder always stays below the divisor while a division runs.
    `HRPD_ASSERT_ALWAYS(a_div_rem_bound, !div_busy || (r_div_rem < r_div_den), "divider remainder out of range")
    // A sample transaction is followed by a busy cycle.
    `HRPD_ASSERT_NEXT(a_busy_after_accept, in_fire, !o_s_axis_tready, "ready held after sample accept")
    // A result never flags an accepted beat without a peak.
    `HRPD_ASSERT_ALWAYS(a_beat_needs_peak, !r_out_valid || !r_out_data[21] || r_out_data[20], "beat without peak")
    // The history slot only takes the three legal positions.
    `HRPD_ASSERT_ALWAYS(a_slot_range, r_slot != 2'd3, "history slot out of range")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the heart rate peak detector core.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import hrpd_pkg::*;

    // One result transaction, laid out as the master tdata bus from the top bit down.
    typedef struct packed {
        logic               due;
        logic [TALLY_W-1:0] count;
        logic [RATE_W-1:0]  rate;
        logic               accepted;
        logic               peak;
        logic [LEVEL_W-1:0] level;
    } beat_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    // One line of the directed stimulus table.
    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] addr;
        logic [15:0]          value;
        bit                   known;
        beat_result_t         want;
    } dir_row_t;

    localparam beat_result_t NO_WANT     = '0;
    localparam int           PHASES      = 9;
    localparam int           PHASE_ITEMS = 128;

    // Clock, reset and block inputs, all known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_tvalid    = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata     = '0;
    logic                  m_tready    = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_TDATA_W-1:0] m_tdata;

    // Predictor copy of the registers.
    logic [THR_W-1:0]  thr_low;
    logic [THR_W-1:0]  thr_high;
    logic [INTV_W-1:0] intv_min;
    logic [INTV_W-1:0] intv_max;
    logic [INTV_W-1:0] period;

    // Predictor copy of the beat state.
    int unsigned          level_q;
    bit                   armed_q;
    logic [TIME_WIDTH-1:0] tick_q;
    logic [TIME_WIDTH-1:0] last_peak_q;
    int unsigned          rate_hist [3];
    int unsigned          hist_slot;
    logic [RATE_W-1:0]    smooth_q;
    logic [TALLY_W-1:0]   tally_q;
    logic [15:0]          since_report_q;

    beat_result_t pending_results [$];
    dir_row_t     dir_tab [$];
    int           errors       = 0;
    int           items_sent   = 0;
    int           results_seen = 0;
    int           peaks_seen   = 0;
    int           beats_seen   = 0;
    int           reports_seen = 0;
    int           burst_left   = 0;

    // Receiver stall pattern state.
    logic [1:0]  stall_mode = 2'd0;
    int          mode_left  = 0;
    logic [31:0] cyc        = '0;

    heart_rate_peak_detector_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Return the predictor to its power-up state.
    task automatic reset_detector();
        thr_low        = RST_LOW_THRESHOLD;
        thr_high       = RST_HIGH_THRESHOLD;
        intv_min       = RST_MIN_INTERVAL;
        intv_max       = RST_MAX_INTERVAL;
        period         = RST_REPORT_PERIOD;
        level_q        = 0;
        armed_q        = 1'b0;
        tick_q         = '0;
        last_peak_q    = '0;
        rate_hist[0]   = 0;
        rate_hist[1]   = 0;
        rate_hist[2]   = 0;
        hist_slot      = 0;
        smooth_q       = '0;
        tally_q        = '0;
        since_report_q = '0;
    endtask

    // Advance the predicted detector by one sample tick.
    task automatic step_detector(input logic [SAMPLE_W-1:0] s, output beat_result_t r);
        logic [TIME_WIDTH-1:0] gap;
        int unsigned           bpm;
        int unsigned           newest;
        int unsigned           middle;
        int unsigned           oldest;
        r      = '0;
        tick_q = tick_q + TIME_WIDTH'(1);
        level_q = (4 * level_q + (int'(s) << FRACTION_BITS)) / 5;
        if (level_q > (int'(thr_high) << FRACTION_BITS) && !armed_q) begin
            r.peak = 1'b1;
            gap = tick_q - last_peak_q;
            if (gap > intv_min && gap < intv_max) begin
                r.accepted = 1'b1;
                bpm = (60000 * 256) / gap;
                if (bpm > 131071) bpm = 131071;
                // Three-entry weighted history, newest entry weighted most.
                if (hist_slot > 2) hist_slot = 0;
                rate_hist[hist_slot] = bpm;
                newest    = hist_slot;
                middle    = (newest + 2) % 3;
                oldest    = (newest + 1) % 3;
                hist_slot = (hist_slot + 1) % 3;
                smooth_q  = RATE_W'((6 * rate_hist[newest] + 3 * rate_hist[middle]
                            + rate_hist[oldest]) / 10);
                if (tally_q != TALLY_MAX) tally_q = tally_q + TALLY_W'(1);
            end
            last_peak_q = tick_q;
            armed_q     = 1'b1;
        end else if (level_q < (int'(thr_low) << FRACTION_BITS)) begin
            armed_q = 1'b0;
        end
        since_report_q = since_report_q + 16'd1;
        if (since_report_q >= period) begin
            r.due          = 1'b1;
            since_report_q = '0;
        end
        r.level = LEVEL_W'(level_q);
        r.rate  = smooth_q;
        r.count = tally_q;
    endtask

    // Offer one sample transaction with bursty pacing and log what it should produce.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit known,
                               input beat_result_t want);
        int           gap_len;
        beat_result_t r;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, s};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        items_sent++;
        step_detector(s, r);
        pending_results.push_back(known ? want : r);
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Write one register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (a)
            CFG_LOW_THRESHOLD:  thr_low  = d[THR_W-1:0];
            CFG_HIGH_THRESHOLD: thr_high = d[THR_W-1:0];
            CFG_MIN_INTERVAL:   intv_min = d;
            CFG_MAX_INTERVAL:   intv_max = d;
            CFG_REPORT_PERIOD:  period   = d;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Choose the register settings of one random phase; the first three are fixed corners.
    task automatic pick_settings(input int p);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] per;
        case (p)
            0: begin
                lo = 16'(RST_LOW_THRESHOLD);  hi = 16'(RST_HIGH_THRESHOLD);
                mn = RST_MIN_INTERVAL;   mx = RST_MAX_INTERVAL;
                per = RST_REPORT_PERIOD;
            end
            1: begin
                lo = 16'd4095; hi = 16'd4095; mn = 16'hFFFF; mx = 16'hFFFF; per = 16'hFFFF;
            end
            2: begin
                lo = 16'd0; hi = 16'd0; mn = 16'd0; mx = 16'd1; per = 16'd1;
            end
            default: begin
                hi = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 4095))
                                                 : 16'($urandom_range(1000, 3500));
                case ($urandom_range(0, 5))
                    0:       lo = 16'd0;
                    1:       lo = 16'($urandom_range(hi, 4095));
                    default: lo = 16'($urandom_range(0, hi));
                endcase
                mn = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
                case ($urandom_range(0, 5))
                    0:       mx = 16'hFFFF;
                    1:       mx = 16'($urandom_range(0, 5));
                    default: mx = (mn > 16'hFFC0) ? 16'hFFFF : mn + 16'($urandom_range(2, 60));
                endcase
                case ($urandom_range(0, 5))
                    0:       per = 16'd0;
                    1:       per = 16'hFFFF;
                    default: per = 16'($urandom_range(1, 50));
                endcase
            end
        endcase
        write_reg(CFG_LOW_THRESHOLD, lo);
        write_reg(CFG_HIGH_THRESHOLD, hi);
        write_reg(CFG_MIN_INTERVAL, mn);
        write_reg(CFG_MAX_INTERVAL, mx);
        write_reg(CFG_REPORT_PERIOD, per);
    endtask

    function automatic dir_row_t sample_row(input logic [SAMPLE_W-1:0] s);
        dir_row_t row;
        row.kind  = ROW_SAMPLE;
        row.addr  = '0;
        row.value = 16'(s);
        row.known = 1'b0;
        row.want  = NO_WANT;
        return row;
    endfunction

    function automatic dir_row_t write_row(input logic [CFG_IDX_W-1:0] a,
                                           input logic [15:0] d);
        dir_row_t row;
        row.kind  = ROW_WRITE;
        row.addr  = a;
        row.value = d;
        row.known = 1'b0;
        row.want  = NO_WANT;
        return row;
    endfunction

    function automatic dir_row_t known_row(input logic [SAMPLE_W-1:0] s,
                                           input beat_result_t w);
        dir_row_t row;
        row       = sample_row(s);
        row.known = 1'b1;
        row.want  = w;
        return row;
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        beat_result_t got;
        beat_result_t exp_r;
        bit           bad;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_mode <= 2'd0;
            mode_left  <= 0;
            cyc        <= '0;
        end else begin
            cyc <= cyc + 32'd1;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (got.peak) peaks_seen++;
                if (got.accepted) beats_seen++;
                if (got.due) reports_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    bad   = 1'b0;
                    if (got.level !== exp_r.level) begin
                        $display("%0t: filtered_level expected %0d actual %0d",
                                 $time, exp_r.level, got.level);
                        bad = 1'b1;
                    end
                    if (got.peak !== exp_r.peak) begin
                        $display("%0t: peak_seen expected %0d actual %0d",
                                 $time, exp_r.peak, got.peak);
                        bad = 1'b1;
                    end
                    if (got.accepted !== exp_r.accepted) begin
                        $display("%0t: beat_accepted expected %0d actual %0d",
                                 $time, exp_r.accepted, got.accepted);
                        bad = 1'b1;
                    end
                    if (got.rate !== exp_r.rate) begin
                        $display("%0t: smoothed_rate expected %0d actual %0d",
                                 $time, exp_r.rate, got.rate);
                        bad = 1'b1;
                    end
                    if (got.count !== exp_r.count) begin
                        $display("%0t: beat_count expected %0d actual %0d",
                                 $time, exp_r.count, got.count);
                        bad = 1'b1;
                    end
                    if (got.due !== exp_r.due) begin
                        $display("%0t: report_due expected %0d actual %0d",
                                 $time, exp_r.due, got.due);
                        bad = 1'b1;
                    end
                    if (bad) errors++;
                end
            end
            // The stall style is redrawn each time its random countdown runs out.
            if (mode_left == 0) begin
                stall_mode <= 2'($urandom_range(0, 3));
                mode_left  <= $urandom_range(100, 600);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (cyc[3:0] < 4'd11);
            endcase
        end
    end

    // Main stimulus: reset, directed table, random phases, final drain.
    initial begin
        int  n;
        int  len;
        int  k;
        bit  prev_write;
        reset_detector();

        // Power-up and the first step: first row is all zeros, the second a full-scale step.
        dir_tab.push_back(known_row(12'd0, NO_WANT));
        dir_tab.push_back(known_row(12'd4095, '{due: 1'b0, count: '0, rate: '0,
                                                accepted: 1'b0, peak: 1'b0,
                                                level: 20'd209664}));
        // Rising level crosses the default high threshold long before the minimum interval.
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd0));
        // Low above high rearms at once, an open window and a zero report period:
        // peaks on every other tick with saturated rates into a zero-filled history.
        dir_tab.push_back(write_row(CFG_LOW_THRESHOLD, 16'd4095));
        dir_tab.push_back(write_row(CFG_HIGH_THRESHOLD, 16'd0));
        dir_tab.push_back(write_row(CFG_MIN_INTERVAL, 16'd0));
        dir_tab.push_back(write_row(CFG_MAX_INTERVAL, 16'hFFFF));
        dir_tab.push_back(write_row(CFG_REPORT_PERIOD, 16'd0));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd0));
        dir_tab.push_back(sample_row(12'd2048));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd1));
        dir_tab.push_back(sample_row(12'd4095));
        // Unreachable high threshold and an inverted window.
        dir_tab.push_back(write_row(CFG_LOW_THRESHOLD, 16'd0));
        dir_tab.push_back(write_row(CFG_HIGH_THRESHOLD, 16'd4095));
        dir_tab.push_back(write_row(CFG_MIN_INTERVAL, 16'hFFFF));
        dir_tab.push_back(write_row(CFG_MAX_INTERVAL, 16'd1));
        dir_tab.push_back(write_row(CFG_REPORT_PERIOD, 16'hFFFF));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd0));
        dir_tab.push_back(sample_row(12'd4095));
        // A window one tick wide accepts nothing; reports on every tick.
        dir_tab.push_back(write_row(CFG_LOW_THRESHOLD, 16'd1500));
        dir_tab.push_back(write_row(CFG_HIGH_THRESHOLD, 16'd2000));
        dir_tab.push_back(write_row(CFG_MIN_INTERVAL, 16'd3));
        dir_tab.push_back(write_row(CFG_MAX_INTERVAL, 16'd4));
        dir_tab.push_back(write_row(CFG_REPORT_PERIOD, 16'd1));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd4095));
        dir_tab.push_back(sample_row(12'd0));
        dir_tab.push_back(sample_row(12'd0));
        dir_tab.push_back(sample_row(12'd4095));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Walk the directed table; writes only happen once the block has gone quiet.
        prev_write = 1'b0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                if (!prev_write) drain_results();
                write_reg(dir_tab[i].addr, dir_tab[i].value);
                prev_write = 1'b1;
            end else begin
                send_sample(dir_tab[i].value[SAMPLE_W-1:0], dir_tab[i].known, dir_tab[i].want);
                prev_write = 1'b0;
            end
        end

        // Random phases: mostly pulse trains shaped around the thresholds, some noise.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            pick_settings(p);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 5 && n >= 60 && n < 64) drain_results();
                if ($urandom_range(0, 9) < 8) begin
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len && n < PHASE_ITEMS; k++) begin
                        send_sample(12'($urandom_range(thr_high, 4095)), 1'b0, NO_WANT);
                        n++;
                    end
                    len = $urandom_range(2, 25);
                    for (k = 0; k < len && n < PHASE_ITEMS; k++) begin
                        send_sample(12'($urandom_range(0, thr_low)), 1'b0, NO_WANT);
                        n++;
                    end
                end else begin
                    len = $urandom_range(1, 10);
                    for (k = 0; k < len && n < PHASE_ITEMS; k++) begin
                        send_sample(12'($urandom), 1'b0, NO_WANT);
                        n++;
                    end
                end
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d samples over %0d register settings; %0d results checked.",
                 items_sent, PHASES + 4, results_seen);
        $display("Seen %0d peaks, %0d accepted beats and %0d report flags.",
                 peaks_seen, beats_seen, reports_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
